FILE: rtl/core/lcts_pkg.sv
// ----------------------------------------------------------------------------
// lcts_pkg
// Shared types and character codes for the line comment token splitter.
// ----------------------------------------------------------------------------
package lcts_pkg;

   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_NUL   = 8'h00;

   // One result beat.
   typedef struct packed {
      logic       err;
      logic       last;
      logic       has;
      logic [7:0] tok_byte;
   } res_type;

   // Queue entry: every result beat one input byte causes.
   typedef struct packed {
      logic    two;
      res_type second;
      res_type first;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

FILE: rtl/core/lcts_front.sv
// ----------------------------------------------------------------------------
// lcts_front
// Accepts text bytes, classifies them, keeps the lexer flags and pushes the
// resulting beats into the queue.
// ----------------------------------------------------------------------------
module lcts_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,
   input  logic                  req_tlast,
   input  lcts_pkg::q_status_type q_status,
   output logic                  push,
   output lcts_pkg::entry_type   push_entry
);

   logic in_string_ff, in_string_in;
   logic token_open_ff, token_open_in;
   logic line_start_ff, line_start_in;
   logic skip_ff, skip_in;
   logic [1:0] n_res;
   logic accept;
   logic blank, punct;
   logic [7:0] c;

   assign c          = req_tdata;
   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;
   assign push       = accept && (n_res != 2'd0);

   always_comb begin
      blank = (c == 8'h20) || (c inside {[8'h09:8'h0D]});
      punct = c inside {[8'h21:8'h2F], [8'h3A:8'h40], [8'h5B:8'h60], [8'h7B:8'h7E]};
   end

   always_comb begin
      in_string_in  = in_string_ff;
      token_open_in = token_open_ff;
      line_start_in = line_start_ff;
      skip_in       = skip_ff;
      n_res         = 2'd0;
      push_entry    = '0;
      if (req_tlast || c == lcts_pkg::CH_LF || c == lcts_pkg::CH_CR ||
          (!skip_ff && c == lcts_pkg::CH_NUL)) begin
         // close the open token and any open string
         if (token_open_ff || in_string_ff) begin
            push_entry.first.last = token_open_ff;
            push_entry.first.err  = in_string_ff;
            n_res                 = 2'd1;
         end
         token_open_in = 1'b0;
         in_string_in  = 1'b0;
         if (req_tlast || c != lcts_pkg::CH_NUL) begin
            line_start_in = 1'b1;
            skip_in       = 1'b0;
         end else begin
            skip_in = 1'b1;
         end
      end else if (skip_ff) begin
         // drop the rest of a skipped line
      end else if (line_start_ff && blank) begin
         // leading blanks keep the line start
      end else if (line_start_ff && c == lcts_pkg::CH_HASH) begin
         line_start_in = 1'b0;
         skip_in       = 1'b1;
      end else begin
         line_start_in = 1'b0;
         if (c == lcts_pkg::CH_QUOTE) begin
            in_string_in = !in_string_ff;
         end else if (in_string_ff || !(blank || (punct && c != lcts_pkg::CH_UNDER))) begin
            push_entry.first.tok_byte = c;
            push_entry.first.has      = 1'b1;
            token_open_in             = 1'b1;
            n_res                     = 2'd1;
         end else if (blank) begin
            if (token_open_ff) begin
               push_entry.first.last = 1'b1;
               n_res                 = 2'd1;
            end
            token_open_in = 1'b0;
         end else begin
            // punctuation: optional end marker, then a one-byte token
            if (token_open_ff) begin
               push_entry.first.last      = 1'b1;
               push_entry.second.tok_byte = c;
               push_entry.second.has      = 1'b1;
               push_entry.second.last     = 1'b1;
               push_entry.two             = 1'b1;
               n_res                      = 2'd2;
            end else begin
               push_entry.first.tok_byte = c;
               push_entry.first.has      = 1'b1;
               push_entry.first.last     = 1'b1;
               n_res                     = 2'd1;
            end
            token_open_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_string_ff  <= 1'b0;
         token_open_ff <= 1'b0;
         line_start_ff <= 1'b1;
         skip_ff       <= 1'b0;
      end else if (accept) begin
         in_string_ff  <= in_string_in;
         token_open_ff <= token_open_in;
         line_start_ff <= line_start_in;
         skip_ff       <= skip_in;
      end
   end

endmodule

FILE: rtl/core/lcts_queue.sv
// ----------------------------------------------------------------------------
// lcts_queue
// Short first-in first-out queue of result entries between front and back.
// ----------------------------------------------------------------------------
module lcts_queue #(
   parameter int DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  lcts_pkg::entry_type    push_entry,
   input  logic                   pop,
   output lcts_pkg::entry_type    head,
   output lcts_pkg::q_status_type q_status
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   lcts_pkg::entry_type slot_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic do_push, do_pop;

   assign q_status.full  = (count_ff == CW'(DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign do_push        = push && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign head           = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

FILE: rtl/core/lcts_back.sv
// ----------------------------------------------------------------------------
// lcts_back
// Drains queue entries and sends their beats, one per cycle while rsp_ is
// not stalled, through the output register.
// ----------------------------------------------------------------------------
module lcts_back (
   input  logic                   clock,
   input  logic                   reset,
   input  lcts_pkg::q_status_type q_status,
   input  lcts_pkg::entry_type    head,
   output logic                   pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,
   output logic [1:0]             rsp_tuser,
   output logic                   rsp_tlast
);

   logic              out_vld_ff;
   lcts_pkg::res_type out_res_ff;
   logic              sec_vld_ff;
   lcts_pkg::res_type sec_res_ff;
   logic              advance;

   assign advance = !out_vld_ff || rsp_tready;
   assign pop     = advance && !sec_vld_ff && !q_status.empty;

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_res_ff.tok_byte;
   assign rsp_tuser  = {out_res_ff.err, out_res_ff.has};
   assign rsp_tlast  = out_res_ff.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
         sec_vld_ff <= 1'b0;
      end else if (advance) begin
         if (sec_vld_ff) begin
            out_vld_ff <= 1'b1;
            sec_vld_ff <= 1'b0;
         end else if (!q_status.empty) begin
            out_vld_ff <= 1'b1;
            sec_vld_ff <= head.two;
         end else begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (sec_vld_ff) begin
            out_res_ff <= sec_res_ff;
         end else if (!q_status.empty) begin
            out_res_ff <= head.first;
            sec_res_ff <= head.second;
         end
      end
   end

endmodule

FILE: rtl/core/line_comment_token_splitter.sv
// ----------------------------------------------------------------------------
// line_comment_token_splitter
// Streaming tokenizer with string mode and line comments: one text byte in,
// zero to two token beats out.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata               | tuser                     | tlast
//  req_     | in  | [7:0] text_byte     | -                         | end_of_input
//  rsp_     | out | [7:0] token_byte    | [0] has_byte, [1] error   | token_last
//
//  A byte is taken every cycle the queue has room; the flag update in the
//  front decides its beats in the same cycle; they pass the queue and the
//  output register to rsp_. A byte that ends a token with punctuation yields
//  two beats, so the back end sends two beats for one byte: the output port
//  limits sustained rate to one beat per cycle. Reset is synchronous, active
//  high, and clears the flags, the queue and the output register. A stall at
//  rsp_ fills the queue (QUEUE_DEPTH entries) before req_tready drops.
// ----------------------------------------------------------------------------
module line_comment_token_splitter #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] text_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] token_byte
   output logic [1:0] rsp_tuser,   // [0] has_byte, [1] open_string_error
   output logic       rsp_tlast
);

   // queue handshake between the two halves
   lcts_pkg::q_status_type q_status;
   lcts_pkg::entry_type    push_entry;
   lcts_pkg::entry_type    head;
   logic                   push;
   logic                   pop;

   // classify each byte and keep the lexer flags
   lcts_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   // decouple front from back so each can stall on its own
   lcts_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .q_status   (q_status)
   );

   // serialise entries into beats and hold them under backpressure
   lcts_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: rtl/core/lcts_checker.sv
// ----------------------------------------------------------------------------
// lcts_checker
// Port-level checks for the token splitter, bound to the top level.
// ----------------------------------------------------------------------------
module lcts_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [1:0] rsp_tuser,
   input logic       rsp_tlast
);

   // a stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp beat changed under stall");

   // a marker beat carries a zero byte
   a_marker_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 8'h00)
      else $error("marker beat with nonzero byte");

   // a marker beat closes a token or reports an open string
   a_marker_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast || rsp_tuser[1])
      else $error("empty marker beat");

   // the error flag rides only on markers
   a_err_no_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> !rsp_tuser[0])
      else $error("error flag on a byte beat");

   // nothing is offered straight after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

endmodule

bind line_comment_token_splitter lcts_checker u_lcts_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
